>>> design/ptn_pkg.sv
`default_nettype none

package ptn_pkg;

  localparam int unsigned MaxStreamsDef = 16;
  localparam int unsigned ActiveW = 5;
  localparam logic [ActiveW-1:0] ActiveStreamsRst = 5'd16;

  localparam logic signed [63:0] TsMin = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] TsMax = {1'b0, {63{1'b1}}};

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_STREAM = 3'd1,
    ST_UNTIMED    = 3'd2,
    ST_INFER_OVF  = 3'd3,
    ST_MEDIAN_OVF = 3'd4,
    ST_MONO_OVF   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]         stream_number;
    logic signed [63:0] pts_in;
    logic               pts_present;
    logic signed [63:0] dts_in;
    logic               dts_present;
    logic signed [63:0] packet_duration;
  } ptn_in_t;

  typedef struct packed {
    logic signed [63:0] pts_out;
    logic signed [63:0] dts_out;
    status_e            status;
  } ptn_out_t;

  typedef struct packed {
    logic               valid;
    logic signed [63:0] last_dts;
    logic signed [63:0] last_dur;
  } ptn_entry_t;

  typedef struct packed {
    logic               en;
    logic signed [63:0] dts;
    logic signed [63:0] dur;
  } ptn_wr_t;

endpackage

`default_nettype wire

>>> design/ptn_table.sv
`default_nettype none

module ptn_table #(
  parameter int unsigned MaxStreams = ptn_pkg::MaxStreamsDef,
  parameter int unsigned IdxW = (MaxStreams > 1) ? $clog2(MaxStreams) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IdxW-1:0]   rd_idx_i,
  output ptn_pkg::ptn_entry_t    rd_o,
  input  wire logic [IdxW-1:0]   wr_idx_i,
  input  wire ptn_pkg::ptn_wr_t  wr_i
);
  import ptn_pkg::*;

  logic [MaxStreams-1:0] valid_q;
  logic signed [63:0]    dts_q [MaxStreams];
  logic signed [63:0]    dur_q [MaxStreams];
  logic                  rd_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      dts_q[wr_idx_i] <= wr_i.dts;
      dur_q[wr_idx_i] <= wr_i.dur;
    end
  end

  // an entry never written reads as the reset value
  always_comb begin
    rd_in_range = 32'(rd_idx_i) < MaxStreams;
    rd_o.valid  = rd_in_range && valid_q[rd_idx_i];
    rd_o.last_dts = rd_o.valid ? dts_q[rd_idx_i] : TsMin;
    rd_o.last_dur = rd_o.valid ? dur_q[rd_idx_i] : 64'sd0;
  end

`ifndef NO_ASSERTIONS
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> valid_q[$past(wr_idx_i)])
    else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

>>> design/ptn_fix.sv
`default_nettype none

module ptn_fix #(
  parameter int unsigned MaxStreams = ptn_pkg::MaxStreamsDef
) (
  input  wire ptn_pkg::ptn_in_t             beat_i,
  input  wire logic [ptn_pkg::ActiveW-1:0]  active_i,
  input  wire ptn_pkg::ptn_entry_t          entry_i,
  output ptn_pkg::ptn_out_t                 res_o,
  output logic                              ok_o
);
  import ptn_pkg::*;

  logic [8:0]         sn_w;
  logic               bad;
  logic               none_present;
  logic signed [63:0] last;
  logic signed [63:0] dur_eff;
  logic signed [64:0] infer_sum;
  logic               infer_ovf;
  logic               last_max;
  logic signed [63:0] next;
  logic signed [63:0] p1, d1, p2, d2, p3, d3;
  logic signed [63:0] dmin, med;
  logic               med_hit, mono_hit;
  status_e            status;

  always_comb begin
    sn_w = {1'b0, beat_i.stream_number};
    bad = (sn_w >= {4'b0, active_i}) || (sn_w >= 9'(MaxStreams));
    none_present = !beat_i.pts_present && !beat_i.dts_present;
    last = entry_i.last_dts;
    last_max = (last == TsMax);
    next = last + 64'sd1;

    // inferred time: last plus max(duration, 1)
    dur_eff = (entry_i.last_dur > 64'sd1) ? entry_i.last_dur : 64'sd1;
    infer_sum = {last[63], last} + {dur_eff[63], dur_eff};
    infer_ovf = infer_sum[64] != infer_sum[63];

    if (none_present) begin
      p1 = infer_sum[63:0];
      d1 = infer_sum[63:0];
    end else if (!beat_i.pts_present) begin
      p1 = beat_i.dts_in;
      d1 = beat_i.dts_in;
    end else if (!beat_i.dts_present) begin
      p1 = beat_i.pts_in;
      d1 = beat_i.pts_in;
    end else begin
      p1 = beat_i.pts_in;
      d1 = beat_i.dts_in;
    end

    // median of pts, dts, last+1 with pts below dts
    med_hit = d1 > p1;
    dmin = (d1 < next) ? d1 : next;
    med = (p1 > dmin) ? p1 : dmin;
    p2 = med_hit ? med : p1;
    d2 = med_hit ? med : d1;

    mono_hit = entry_i.valid && (d2 <= last);
    if (mono_hit) begin
      p3 = (p2 >= d2) ? ((p2 > next) ? p2 : next) : p2;
      d3 = next;
    end else begin
      p3 = p2;
      d3 = d2;
    end

    priority if (bad) begin
      status = ST_BAD_STREAM;
    end else if (none_present && !entry_i.valid) begin
      status = ST_UNTIMED;
    end else if (none_present && infer_ovf) begin
      status = ST_INFER_OVF;
    end else if (med_hit && last_max) begin
      status = ST_MEDIAN_OVF;
    end else if (mono_hit && last_max) begin
      status = ST_MONO_OVF;
    end else begin
      status = ST_OK;
    end

    ok_o = (status == ST_OK);
    res_o.status  = status;
    res_o.pts_out = ok_o ? p3 : 64'sd0;
    res_o.dts_out = ok_o ? d3 : 64'sd0;
  end

endmodule

`default_nettype wire

>>> design/packet_timestamp_normalizer.sv
// channel  | valid        | stall        | beat
// ---------+--------------+--------------+-------------------------------
// in       | in_valid_i   | in_stall_o   | in_beat_i  (ptn_in_t)
// out      | out_valid_o  | out_stall_i  | out_beat_o (ptn_out_t)
// cfg      | cfg_we_i     | none         | cfg_wdata_i (active_streams)
//
// one beat per cycle sustained while the output is not stalled; a beat passes
// through the input register, then the result register, to the output
// the per-stream table is read and written while a beat sits between the two
// registers, so back-to-back beats of one stream see each other's update
// reset clears the table valid bits and sets active_streams to 16
// a stall on the output holds the result register and backs up into the
// input register; input stall rises only when both hold a beat
`default_nettype none

module packet_timestamp_normalizer #(
  parameter int unsigned MaxStreams = ptn_pkg::MaxStreamsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ptn_pkg::ActiveW-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ptn_pkg::ptn_in_t             in_beat_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ptn_pkg::ptn_out_t                 out_beat_o
);
  import ptn_pkg::*;

  localparam int unsigned IdxW = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;

  logic [ActiveW-1:0] act_q;
  logic               a_valid_q;
  ptn_in_t            a_beat_q;
  logic               o_valid_q;
  ptn_out_t           o_beat_q;

  logic               o_adv;
  logic               a_load;
  logic [IdxW-1:0]    idx;
  ptn_entry_t         rd_entry;
  ptn_wr_t            wr;
  ptn_out_t           fix_res;
  logic               fix_ok;

  assign o_adv      = !o_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !o_adv;
  assign a_load     = in_valid_i && !in_stall_o;
  assign idx        = a_beat_q.stream_number[IdxW-1:0];

  assign out_valid_o = o_valid_q;
  assign out_beat_o  = o_beat_q;

  always_comb begin
    wr.en  = a_valid_q && o_adv && fix_ok;
    wr.dts = fix_res.dts_out;
    wr.dur = a_beat_q.packet_duration;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= ActiveStreamsRst;
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        a_valid_q <= in_valid_i;
      end
      if (o_adv) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_beat_q <= in_beat_i;
    end
    if (o_adv && a_valid_q) begin
      o_beat_q <= fix_res;
    end
  end

  ptn_table #(
    .MaxStreams (MaxStreams),
    .IdxW       (IdxW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx),
    .rd_o     (rd_entry),
    .wr_idx_i (idx),
    .wr_i     (wr)
  );

  ptn_fix #(
    .MaxStreams (MaxStreams)
  ) u_fix (
    .beat_i   (a_beat_q),
    .active_i (act_q),
    .entry_i  (rd_entry),
    .res_o    (fix_res),
    .ok_o     (fix_ok)
  );

`ifndef NO_ASSERTIONS
  a_err_zeroes_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && (o_beat_q.status != ST_OK)) |->
      ((o_beat_q.pts_out == 64'sd0) && (o_beat_q.dts_out == 64'sd0)))
    else $error("error result carries nonzero times");

  a_dts_increases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && fix_ok && rd_entry.valid) |-> (fix_res.dts_out > rd_entry.last_dts))
    else $error("decode time not above last written");

  a_pts_not_below_dts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && fix_ok) |-> (fix_res.pts_out >= fix_res.dts_out))
    else $error("pts below dts on good result");
`endif

endmodule

`default_nettype wire

>>> dv/packet_timestamp_normalizer_tb.sv
`default_nettype none

module packet_timestamp_normalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptn_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomPhaseLen = 400;

  class timestamp_checker;
    logic [ActiveW-1:0] active_streams;
    longint             last_dts[MaxStreamsDef];
    longint             last_dur[MaxStreamsDef];
    bit                 has_entry[MaxStreamsDef];
    ptn_out_t           expected_stamps[$];
    int unsigned        mismatches;
    int unsigned        stamps_checked;
    int unsigned        status_hits[6];

    function new();
      active_streams = ActiveStreamsRst;
      for (int i = 0; i < MaxStreamsDef; i++) begin
        last_dts[i] = TsMin;
        last_dur[i] = 0;
        has_entry[i] = 1'b0;
      end
      mismatches = 0;
      stamps_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_stamps.size();
    endfunction

    // per-stream timestamp cleanup; state only moves on success
    function ptn_out_t normalize_packet(ptn_in_t b);
      ptn_out_t o;
      longint pts, dts, last, step, nxt, c;
      bit valid;
      int unsigned lim, s;
      o = '0;
      o.status = ST_OK;
      lim = (active_streams > MaxStreamsDef) ? MaxStreamsDef : active_streams;
      if (b.stream_number >= lim) begin
        o.status = ST_BAD_STREAM;
        return o;
      end
      s = b.stream_number;
      pts = b.pts_in;
      dts = b.dts_in;
      last = last_dts[s];
      valid = has_entry[s];
      if (!b.pts_present && !b.dts_present) begin
        if (!valid) begin
          o.status = ST_UNTIMED;
          return o;
        end
        step = (last_dur[s] > 1) ? last_dur[s] : 1;
        if (last > TsMax - step) begin
          o.status = ST_INFER_OVF;
          return o;
        end
        pts = last + step;
        dts = pts;
      end else if (!b.pts_present) begin
        pts = dts;
      end else if (!b.dts_present) begin
        dts = pts;
      end
      // median of pts, dts and last + 1
      if (dts > pts) begin
        if (last == TsMax) begin
          o.status = ST_MEDIAN_OVF;
          return o;
        end
        nxt = last + 1;
        c = (dts < nxt) ? dts : nxt;
        c = (pts > c) ? pts : c;
        pts = c;
        dts = c;
      end
      if (valid && dts <= last) begin
        if (last == TsMax) begin
          o.status = ST_MONO_OVF;
          return o;
        end
        nxt = last + 1;
        if (pts >= dts && nxt > pts) pts = nxt;
        dts = nxt;
      end
      last_dts[s] = dts;
      last_dur[s] = b.packet_duration;
      has_entry[s] = 1'b1;
      o.pts_out = pts;
      o.dts_out = dts;
      return o;
    endfunction

    function void note_packet(ptn_in_t b);
      ptn_out_t o;
      o = normalize_packet(b);
      status_hits[int'(o.status)]++;
      expected_stamps.push_back(o);
    endfunction

    function void check_stamp(ptn_out_t r);
      ptn_out_t e;
      stamps_checked++;
      if (expected_stamps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat pts=%0d dts=%0d status=%0d", $realtime,
                   r.pts_out, r.dts_out, r.status);
        return;
      end
      e = expected_stamps.pop_front();
      if (r.pts_out !== e.pts_out || r.dts_out !== e.dts_out || r.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp pts=%0d dts=%0d status=%0d, got pts=%0d dts=%0d status=%0d",
                   $realtime, e.pts_out, e.dts_out, e.status,
                   r.pts_out, r.dts_out, r.status);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [ActiveW-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ptn_in_t            in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ptn_out_t           out_beat;

  logic [31:0]        cycles = '0;
  int unsigned        burst_left = 1;
  int unsigned        packets_sent = 0;
  int unsigned        settings_used = 1;
  timestamp_checker   sb;

  packet_timestamp_normalizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #4 clk_i = ~clk_i;

  // output stall pattern cycles through none, light, heavy and periodic
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    case (cycles[10:9])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycles % 5) < 2);
    endcase
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_stamp(out_beat);
  end

  function automatic ptn_in_t make_packet(int unsigned sn, longint pts, bit pp,
                                          longint dts, bit dp, longint dur);
    ptn_in_t b;
    b.stream_number = sn[7:0];
    b.pts_in = pts;
    b.pts_present = pp;
    b.dts_in = dts;
    b.dts_present = dp;
    b.packet_duration = dur;
    return b;
  endfunction

  function automatic ptn_in_t random_packet();
    ptn_in_t b;
    int unsigned lim, kind, flags;
    longint base, v;
    lim = (sb.active_streams > MaxStreamsDef) ? MaxStreamsDef : sb.active_streams;
    kind = $urandom_range(0, 99);
    if (lim == 0) kind = 99;
    b.stream_number = (lim == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
    b.pts_present = 1'b1;
    b.dts_present = 1'b1;
    b.packet_duration = $urandom_range(1, 3000);
    if ($urandom_range(0, 19) == 0)
      b.packet_duration = -longint'($urandom_range(0, 1000));
    if (kind < 72) begin
      // well-formed stream continuation, some jitter and missing stamps
      base = sb.has_entry[b.stream_number] ? sb.last_dts[b.stream_number]
                                           : longint'($urandom_range(0, 100000));
      b.dts_in = base + longint'($urandom_range(0, 3000));
      if ($urandom_range(0, 9) == 0) b.dts_in = b.dts_in - longint'($urandom_range(0, 5000));
      if (kind < 60) b.pts_in = b.dts_in + longint'($urandom_range(0, 6000));
      else b.pts_in = b.dts_in - longint'($urandom_range(1, 6000));
      flags = $urandom_range(0, 19);
      if (flags == 0 || flags == 2) b.pts_present = 1'b0;
      if (flags == 1 || flags == 2) b.dts_present = 1'b0;
    end else if (kind < 82) begin
      if (lim >= 4 && $urandom_range(0, 3) == 0) begin
        b.stream_number = 8'(lim - 1);
        v = TsMax - longint'($urandom_range(0, 5000));
      end else begin
        v = TsMin + longint'($urandom_range(0, 5000));
      end
      b.dts_in = v;
      b.pts_in = v + longint'($urandom_range(0, 20)) - 10;
      b.pts_present = $urandom_range(0, 1);
      b.dts_present = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: b.packet_duration = TsMax;
        1: b.packet_duration = TsMin;
        2: b.packet_duration = TsMax - longint'($urandom_range(0, 100));
        default: b.packet_duration = 1;
      endcase
    end else if (kind < 94) begin
      b.pts_in = {$urandom, $urandom};
      b.dts_in = {$urandom, $urandom};
      b.packet_duration = {$urandom, $urandom};
      b.pts_present = $urandom_range(0, 1);
      b.dts_present = $urandom_range(0, 1);
    end else begin
      b.stream_number = 8'($urandom_range(lim, 255));
      b.pts_in = {$urandom, $urandom};
      b.dts_in = {$urandom, $urandom};
      b.packet_duration = {$urandom, $urandom};
      b.pts_present = $urandom_range(0, 1);
      b.dts_present = $urandom_range(0, 1);
    end
    return b;
  endfunction

  task automatic send_packet(input ptn_in_t b);
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk_i); while (in_stall);
    sb.note_packet(b);
    packets_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active_streams(input logic [ActiveW-1:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.active_streams = v;
    settings_used++;
  endtask

  initial begin
    logic [ActiveW-1:0] phase_setting[5];
    sb = new();
    burst_left = $urandom_range(1, 16);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fresh stream with no stamps, then inference and fixes on stream 0
    send_packet(make_packet(0, 0, 0, 0, 0, 10));
    send_packet(make_packet(0, 100, 1, 90, 1, 10));
    send_packet(make_packet(0, 0, 0, 0, 0, 10));
    send_packet(make_packet(0, 0, 0, 95, 1, 0));
    send_packet(make_packet(0, 500, 1, 0, 0, -5));
    send_packet(make_packet(0, 0, 0, 0, 0, 0));
    send_packet(make_packet(0, 600, 1, 700, 1, 3));
    // median on a stream with no entry yet
    send_packet(make_packet(1, 50, 1, 80, 1, 1));
    // minimum int64 as a real decode time
    send_packet(make_packet(2, TsMin, 1, TsMin, 1, 0));
    send_packet(make_packet(2, TsMin, 1, TsMin, 1, 0));
    send_packet(make_packet(2, 0, 0, 0, 0, TsMax));
    send_packet(make_packet(2, 0, 0, 0, 0, 0));
    // overflow at the top of the range
    send_packet(make_packet(13, TsMax - 5, 1, TsMax - 5, 1, 100));
    send_packet(make_packet(13, 0, 0, 0, 0, 0));
    send_packet(make_packet(14, TsMax, 1, TsMax, 1, 1));
    send_packet(make_packet(14, 3, 1, 5, 1, 0));
    send_packet(make_packet(14, 7, 1, 7, 1, 0));
    send_packet(make_packet(14, 0, 0, 0, 0, 0));
    send_packet(make_packet(15, TsMax, 1, TsMin, 1, TsMin));
    send_packet(make_packet(16, 1, 1, 1, 1, 1));
    send_packet(make_packet(255, -1, 1, -1, 1, -1));
    send_packet(make_packet(5, -1000, 1, -2000, 1, -1));
    send_packet(make_packet(5, 64'h5555_5555_5555_5555, 1, 64'h2aaa_aaaa_aaaa_aaaa, 1,
                            64'haaaa_aaaa_aaaa_aaaa));

    // stream count extremes, zero and out of range
    set_active_streams(5'd1);
    send_packet(make_packet(0, 800, 1, 800, 1, 2));
    send_packet(make_packet(1, 900, 1, 900, 1, 2));
    set_active_streams(5'd0);
    send_packet(make_packet(0, 900, 1, 900, 1, 2));
    set_active_streams(5'd31);
    send_packet(make_packet(15, 10, 1, 10, 1, 2));
    send_packet(make_packet(16, 10, 1, 10, 1, 2));

    phase_setting[0] = 5'd16;
    phase_setting[1] = 5'd1;
    phase_setting[2] = 5'($urandom_range(2, 15));
    phase_setting[3] = 5'd16;
    phase_setting[4] = 5'($urandom_range(2, 15));
    foreach (phase_setting[p]) begin
      set_active_streams(phase_setting[p]);
      repeat (RandomPhaseLen) send_packet(random_packet());
    end

    wait_quiet();
    $display("sent %0d packets over %0d stream-count settings, %0d results checked",
             packets_sent, settings_used, sb.stamps_checked);
    $display("status mix ok=%0d bad=%0d untimed=%0d infer=%0d median=%0d mono=%0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
